// ----- hw/rtl/sbpc_pkg.sv -----
`timescale 1ns / 1ps
package sbpc_pkg;

   localparam int DIM_CFG_W   = 13;
   localparam int STRIDE_W    = 15;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int COORD_W     = 12;
   localparam int OFFSET_W    = 26;
   localparam int PIXEL_W     = 32;
   localparam int WORD_W      = 32;
   localparam int COLOR_W     = 24;
   localparam int PAL_DEPTH   = 256;
   localparam int PAL_IDX_W   = 8;
   localparam int BPP_W       = 3;

   typedef enum logic [1:0] {
      OP_PAL_WRITE = 2'd0,
      OP_ADDR_REQ  = 2'd1,
      OP_CONVERT   = 2'd2,
      OP_RESERVED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SRC_PAL8   = 2'd0,
      SRC_RGB565 = 2'd1,
      SRC_BGR24  = 2'd2,
      SRC_BGRA32 = 2'd3
   } src_fmt_type;

   typedef enum logic [1:0] {
      DST_ARGB32   = 2'd0,
      DST_RGB565   = 2'd1,
      DST_ARGB1555 = 2'd2,
      DST_NONE     = 2'd3
   } dst_fmt_type;

   typedef enum logic {
      KIND_ADDR  = 1'b0,
      KIND_PIXEL = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_SRC_STRIDE = 3'd2,
      CSR_DST_WIDTH  = 3'd3,
      CSR_DST_HEIGHT = 3'd4,
      CSR_SRC_FORMAT = 3'd5,
      CSR_DST_FORMAT = 3'd6
   } csr_idx_type;

   function automatic logic [PIXEL_W-1:0] convert_pixel(
      input src_fmt_type          sfmt,
      input dst_fmt_type          dfmt,
      input logic [WORD_W-1:0]    word,
      input logic [COLOR_W-1:0]   entry
   );
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic [7:0] a;
      logic [PIXEL_W-1:0] pix;
      a = 8'hFF;
      unique case (sfmt)
         SRC_PAL8: begin
            b = entry[7:0];
            g = entry[15:8];
            r = entry[23:16];
         end
         SRC_RGB565: begin
            b = {word[4:0], 3'b000};
            g = {word[10:5], 2'b00};
            r = {word[15:11], 3'b000};
         end
         SRC_BGR24: begin
            b = word[7:0];
            g = word[15:8];
            r = word[23:16];
         end
         default: begin
            b = word[7:0];
            g = word[15:8];
            r = word[23:16];
            a = word[31:24];
         end
      endcase
      unique case (dfmt)
         DST_ARGB32:   pix = {8'hFF, r, g, b};
         DST_RGB565:   pix = {16'h0000, r[7:3], g[7:2], b[7:3]};
         DST_ARGB1555: pix = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
         default:      pix = '0;
      endcase
      return pix;
   endfunction

endpackage

// ----- hw/rtl/sbpc_if.sv -----
`timescale 1ns / 1ps
interface sbpc_req_if import sbpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic [COORD_W-1:0]   dest_x;
   logic [COORD_W-1:0]   dest_y;
   logic [PAL_IDX_W-1:0] palette_index;
   logic [COLOR_W-1:0]   palette_color;
   logic [WORD_W-1:0]    source_word;

   modport source (output valid, operation, dest_x, dest_y, palette_index,
                   palette_color, source_word, input ready);
   modport sink (input valid, operation, dest_x, dest_y, palette_index,
                 palette_color, source_word, output ready);
endinterface

interface sbpc_rsp_if import sbpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                result_kind;
   logic [OFFSET_W-1:0] source_offset;
   logic [PIXEL_W-1:0]  dest_pixel;
   logic                format_error;

   modport source (output valid, result_kind, source_offset, dest_pixel,
                   format_error, input ready);
   modport sink (input valid, result_kind, source_offset, dest_pixel,
                 format_error, output ready);
endinterface

// ----- hw/rtl/scaled_blit_pixel_converter_unit.sv -----
`timescale 1ns / 1ps
// channel   | direction | contents
// req_bus   | in        | operation, dest_x/y, palette_index/color, source_word
// rsp_bus   | out       | result_kind, source_offset, dest_pixel, format_error
// csr_*     | in        | write enable, register index, write data
// one item per cycle while the output is not stalled; the path runs through stage 1, stage 2,
// the bit-per-stage dividers for the x and y scaling, stage 3 and the output register
// reset is synchronous; control state and palette valid bits clear, config registers take defaults at once
// a stalled output freezes the whole pipe, req ready follows rsp ready or an empty output
module scaled_blit_pixel_converter_unit import sbpc_pkg::*; #(
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   sbpc_req_if.sink              req_bus,
   sbpc_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int DMW    = $clog2(MAX_DIMENSION + 1);
   localparam int NW     = COORD_W + DMW;
   localparam int SIDE_W = 2 + PIXEL_W + DMW + STRIDE_W + BPP_W;
   localparam int OW     = DMW + STRIDE_W + 1;

   // configuration
   logic [DIM_CFG_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [STRIDE_W-1:0]  stride_ff;
   src_fmt_type          src_fmt_ff;
   dst_fmt_type          dst_fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff   <= DIM_CFG_W'(1);
         src_h_ff   <= DIM_CFG_W'(1);
         stride_ff  <= STRIDE_W'(4);
         dst_w_ff   <= DIM_CFG_W'(1);
         dst_h_ff   <= DIM_CFG_W'(1);
         src_fmt_ff <= SRC_BGRA32;
         dst_fmt_ff <= DST_ARGB32;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SRC_WIDTH:  src_w_ff   <= csr_wr_data[DIM_CFG_W-1:0];
            CSR_SRC_HEIGHT: src_h_ff   <= csr_wr_data[DIM_CFG_W-1:0];
            CSR_SRC_STRIDE: stride_ff  <= csr_wr_data[STRIDE_W-1:0];
            CSR_DST_WIDTH:  dst_w_ff   <= csr_wr_data[DIM_CFG_W-1:0];
            CSR_DST_HEIGHT: dst_h_ff   <= csr_wr_data[DIM_CFG_W-1:0];
            CSR_SRC_FORMAT: src_fmt_ff <= src_fmt_type'(csr_wr_data[1:0]);
            CSR_DST_FORMAT: dst_fmt_ff <= dst_fmt_type'(csr_wr_data[1:0]);
            default: ;
         endcase
      end
   end

   function automatic logic [DMW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      if (v == '0) begin
         return DMW'(1);
      end
      if (32'(v) > MAX_DIMENSION) begin
         return DMW'(MAX_DIMENSION);
      end
      return DMW'(v);
   endfunction

   logic advance;
   logic out_vld_ff;
   logic accept;
   op_type op;

   assign advance       = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;
   assign op            = op_type'(req_bus.operation);

   // palette: ram plus per-entry valid bits so reset reads as zero
   logic [PAL_DEPTH-1:0] pal_vld_ff;
   logic                 pal_wr;
   logic [COLOR_W-1:0]   pal_rd_data;

   assign pal_wr = accept && (op == OP_PAL_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pal_wr) begin
         pal_vld_ff[req_bus.palette_index] <= 1'b1;
      end
   end

   sbpc_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (req_bus.palette_index),
      .wr_data (req_bus.palette_color),
      .rd_en   (advance),
      .rd_addr (req_bus.source_word[PAL_IDX_W-1:0]),
      .rd_data (pal_rd_data)
   );

   // stage 1: clamp and saturate
   logic [DMW-1:0]     sw_c, sh_c, dw_c, dh_c;
   logic [COORD_W-1:0] x_sat, y_sat;

   always_comb begin
      sw_c  = clamp_dim(src_w_ff);
      sh_c  = clamp_dim(src_h_ff);
      dw_c  = clamp_dim(dst_w_ff);
      dh_c  = clamp_dim(dst_h_ff);
      x_sat = req_bus.dest_x;
      y_sat = req_bus.dest_y;
      if ((NW)'(req_bus.dest_x) >= (NW)'(dw_c)) begin
         x_sat = COORD_W'(dw_c - DMW'(1));
      end
      if ((NW)'(req_bus.dest_y) >= (NW)'(dh_c)) begin
         y_sat = COORD_W'(dh_c - DMW'(1));
      end
   end

   logic               s1_vld_ff;
   kind_type           s1_kind_ff;
   logic               s1_err_ff;
   logic               s1_ent_vld_ff;
   logic [WORD_W-1:0]  s1_word_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [DMW-1:0]     s1_sw_ff, s1_sh_ff, s1_dw_ff, s1_dh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= accept && (op == OP_ADDR_REQ || op == OP_CONVERT);
      end
      if (advance) begin
         s1_kind_ff    <= (op == OP_CONVERT) ? KIND_PIXEL : KIND_ADDR;
         s1_err_ff     <= (dst_fmt_ff == DST_NONE);
         s1_ent_vld_ff <= pal_vld_ff[req_bus.source_word[PAL_IDX_W-1:0]];
         s1_word_ff    <= req_bus.source_word;
         s1_x_ff       <= x_sat;
         s1_y_ff       <= y_sat;
         s1_sw_ff      <= sw_c;
         s1_sh_ff      <= sh_c;
         s1_dw_ff      <= dw_c;
         s1_dh_ff      <= dh_c;
      end
   end

   // stage 2: scale products and pixel conversion
   logic [COLOR_W-1:0] entry;
   logic [PIXEL_W-1:0] pix_c;

   always_comb begin
      entry = s1_ent_vld_ff ? pal_rd_data : '0;
      pix_c = convert_pixel(src_fmt_ff, dst_fmt_ff, s1_word_ff, entry);
   end

   logic              s2_vld_ff;
   logic [NW-1:0]     s2_nx_ff, s2_ny_ff;
   logic [DMW-1:0]    s2_dw_ff, s2_dh_ff;
   logic [SIDE_W-1:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_nx_ff   <= NW'(s1_x_ff) * NW'(s1_sw_ff);
         s2_ny_ff   <= NW'(s1_y_ff) * NW'(s1_sh_ff);
         s2_dw_ff   <= s1_dw_ff;
         s2_dh_ff   <= s1_dh_ff;
         s2_side_ff <= {s1_kind_ff, s1_err_ff,
                        (s1_kind_ff == KIND_PIXEL) ? pix_c : PIXEL_W'(0),
                        s1_sh_ff, stride_ff, BPP_W'(src_fmt_ff) + BPP_W'(1)};
      end
   end

   logic              d_vld;
   logic [DMW-1:0]    col, qrow;
   logic [SIDE_W-1:0] d_side;

   sbpc_div_pipe #(.NW(NW), .DMW(DMW), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s2_vld_ff),
      .num_x     (s2_nx_ff),
      .num_y     (s2_ny_ff),
      .den_x     (s2_dw_ff),
      .den_y     (s2_dh_ff),
      .side_in   (s2_side_ff),
      .out_valid (d_vld),
      .quot_x    (col),
      .quot_y    (qrow),
      .side_out  (d_side)
   );

   logic               d_kind;
   logic               d_err;
   logic [PIXEL_W-1:0] d_pix;
   logic [DMW-1:0]     d_sh;
   logic [STRIDE_W-1:0] d_stride;
   logic [BPP_W-1:0]   d_bpp;
   logic [DMW-1:0]     row;

   assign {d_kind, d_err, d_pix, d_sh, d_stride, d_bpp} = d_side;
   // rows are stored bottom-up
   assign row = d_sh - DMW'(1) - qrow;

   // stage 3: offset products
   logic               s3_vld_ff;
   kind_type           s3_kind_ff;
   logic               s3_err_ff;
   logic [PIXEL_W-1:0] s3_pix_ff;
   logic [OW-1:0]      s3_rp_ff, s3_cp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= d_vld;
      end
      if (advance) begin
         s3_kind_ff <= kind_type'(d_kind);
         s3_err_ff  <= d_err;
         s3_pix_ff  <= d_pix;
         s3_rp_ff   <= OW'(row) * OW'(d_stride);
         s3_cp_ff   <= OW'(col) * OW'(d_bpp);
      end
   end

   // output register
   logic                out_kind_ff;
   logic                out_err_ff;
   logic [OFFSET_W-1:0] out_off_ff;
   logic [PIXEL_W-1:0]  out_pix_ff;
   logic [OW-1:0]       off_sum;

   assign off_sum = s3_rp_ff + s3_cp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= s3_vld_ff;
      end
      if (advance) begin
         out_kind_ff <= s3_kind_ff;
         out_err_ff  <= s3_err_ff;
         out_pix_ff  <= s3_pix_ff;
         out_off_ff  <= (s3_kind_ff == KIND_ADDR) ? OFFSET_W'(off_sum) : '0;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.result_kind   = out_kind_ff;
   assign rsp_bus.source_offset = out_off_ff;
   assign rsp_bus.dest_pixel    = out_pix_ff;
   assign rsp_bus.format_error  = out_err_ff;
endmodule

// ----- hw/rtl/sbpc_ram.sv -----
`timescale 1ns / 1ps
module sbpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/sbpc_div_pipe.sv -----
`timescale 1ns / 1ps
module sbpc_div_pipe import sbpc_pkg::*; #(
   parameter int NW     = 25,
   parameter int DMW    = 13,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NW-1:0]     num_x,
   input  logic [NW-1:0]     num_y,
   input  logic [DMW-1:0]    den_x,
   input  logic [DMW-1:0]    den_y,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [DMW-1:0]    quot_x,
   output logic [DMW-1:0]    quot_y,
   output logic [SIDE_W-1:0] side_out
);
   // one quotient bit per stage, msb first; quotient always fits DMW bits
   localparam int QW = DMW;
   localparam int RW = (NW > 2 * DMW) ? NW : 2 * DMW;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int K = QW - 1 - i;
      logic              vld_ff;
      logic [RW-1:0]     rx_ff;
      logic [RW-1:0]     ry_ff;
      logic [QW-1:0]     qx_ff;
      logic [QW-1:0]     qy_ff;
      logic [DMW-1:0]    dx_ff;
      logic [DMW-1:0]    dy_ff;
      logic [SIDE_W-1:0] side_ff;
      logic              vld_src;
      logic [RW-1:0]     rx_src;
      logic [RW-1:0]     ry_src;
      logic [QW-1:0]     qx_src;
      logic [QW-1:0]     qy_src;
      logic [DMW-1:0]    dx_src;
      logic [DMW-1:0]    dy_src;
      logic [SIDE_W-1:0] side_src;
      logic [RW-1:0]     shx;
      logic [RW-1:0]     shy;
      logic [RW-1:0]     rx_in;
      logic [RW-1:0]     ry_in;
      logic [QW-1:0]     qx_in;
      logic [QW-1:0]     qy_in;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rx_src   = RW'(num_x);
         assign ry_src   = RW'(num_y);
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign dx_src   = den_x;
         assign dy_src   = den_y;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src  = g_stage[i-1].vld_ff;
         assign rx_src   = g_stage[i-1].rx_ff;
         assign ry_src   = g_stage[i-1].ry_ff;
         assign qx_src   = g_stage[i-1].qx_ff;
         assign qy_src   = g_stage[i-1].qy_ff;
         assign dx_src   = g_stage[i-1].dx_ff;
         assign dy_src   = g_stage[i-1].dy_ff;
         assign side_src = g_stage[i-1].side_ff;
      end

      always_comb begin
         shx   = RW'(dx_src) << K;
         shy   = RW'(dy_src) << K;
         rx_in = rx_src;
         ry_in = ry_src;
         qx_in = qx_src;
         qy_in = qy_src;
         if (rx_src >= shx) begin
            rx_in    = rx_src - shx;
            qx_in[K] = 1'b1;
         end
         if (ry_src >= shy) begin
            ry_in    = ry_src - shy;
            qy_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (enable) begin
            vld_ff <= vld_src;
         end
         if (enable) begin
            rx_ff   <= rx_in;
            ry_ff   <= ry_in;
            qx_ff   <= qx_in;
            qy_ff   <= qy_in;
            dx_ff   <= dx_src;
            dy_ff   <= dy_src;
            side_ff <= side_src;
         end
      end
   end

   assign out_valid = g_stage[QW-1].vld_ff;
   assign quot_x    = g_stage[QW-1].qx_ff;
   assign quot_y    = g_stage[QW-1].qy_ff;
   assign side_out  = g_stage[QW-1].side_ff;
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import sbpc_pkg::*;

   typedef struct packed {
      op_type               operation;
      logic [COORD_W-1:0]   dest_x;
      logic [COORD_W-1:0]   dest_y;
      logic [PAL_IDX_W-1:0] palette_index;
      logic [COLOR_W-1:0]   palette_color;
      logic [WORD_W-1:0]    source_word;
   } blit_item_t;

   typedef struct packed {
      kind_type            result_kind;
      logic [OFFSET_W-1:0] source_offset;
      logic [PIXEL_W-1:0]  dest_pixel;
      logic                format_error;
   } blit_result_t;

   localparam int MAX_DIM = 4096;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   sbpc_req_if req_bus ();
   sbpc_rsp_if rsp_bus ();

   scaled_blit_pixel_converter_unit #(.MAX_DIMENSION(MAX_DIM)) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   blit_item_t   item_queue[$];
   blit_result_t result_queue[$];
   blit_item_t   item_on_bus;
   int           send_idle;
   int           recv_idle;
   int           error_count;

   // shadow of the block's registers and palette
   logic [12:0]        sh_src_w, sh_src_h, sh_dst_w, sh_dst_h;
   logic [14:0]        sh_stride;
   src_fmt_type        sh_src_fmt;
   dst_fmt_type        sh_dst_fmt;
   logic [COLOR_W-1:0] sh_palette [PAL_DEPTH];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint clamp_dim(logic [12:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic logic [OFFSET_W-1:0] sample_offset(logic [11:0] x, logic [11:0] y);
      longint sw, sh, dw, dh, xc, yc, col, row, off;
      sw = clamp_dim(sh_src_w);
      sh = clamp_dim(sh_src_h);
      dw = clamp_dim(sh_dst_w);
      dh = clamp_dim(sh_dst_h);
      xc = (x >= dw) ? dw - 1 : x;
      yc = (y >= dh) ? dh - 1 : y;
      col = (xc * sw) / dw;
      row = sh - 1 - (yc * sh) / dh;
      off = row * sh_stride + col * (longint'(sh_src_fmt) + 1);
      return off[OFFSET_W-1:0];
   endfunction

   function automatic logic [PIXEL_W-1:0] packed_pixel(logic [WORD_W-1:0] w);
      logic [7:0] b, g, r, a;
      logic [COLOR_W-1:0] e;
      a = 8'hFF;
      e = sh_palette[w[7:0]];
      case (sh_src_fmt)
         SRC_PAL8: begin
            b = e[7:0]; g = e[15:8]; r = e[23:16];
         end
         SRC_RGB565: begin
            b = {w[4:0], 3'b0}; g = {w[10:5], 2'b0}; r = {w[15:11], 3'b0};
         end
         SRC_BGR24: begin
            b = w[7:0]; g = w[15:8]; r = w[23:16];
         end
         default: begin
            b = w[7:0]; g = w[15:8]; r = w[23:16]; a = w[31:24];
         end
      endcase
      case (sh_dst_fmt)
         DST_ARGB32:   return {8'hFF, r, g, b};
         DST_RGB565:   return {16'h0, r[7:3], g[7:2], b[7:3]};
         DST_ARGB1555: return {16'h0, (a >= 8'd128), r[7:3], g[7:3], b[7:3]};
         default:      return '0;
      endcase
   endfunction

   task automatic predict_blit(blit_item_t it);
      blit_result_t res;
      res = '0;
      res.format_error = (sh_dst_fmt == DST_NONE);
      case (it.operation)
         OP_PAL_WRITE: sh_palette[it.palette_index] = it.palette_color;
         OP_ADDR_REQ: begin
            res.result_kind = KIND_ADDR;
            res.source_offset = sample_offset(it.dest_x, it.dest_y);
            result_queue.push_back(res);
         end
         OP_CONVERT: begin
            res.result_kind = KIND_PIXEL;
            res.dest_pixel = packed_pixel(it.source_word);
            result_queue.push_back(res);
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) predict_blit(item_on_bus);
         if (item_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
            item_on_bus = item_queue.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.operation     <= item_on_bus.operation;
            req_bus.dest_x        <= item_on_bus.dest_x;
            req_bus.dest_y        <= item_on_bus.dest_y;
            req_bus.palette_index <= item_on_bus.palette_index;
            req_bus.palette_color <= item_on_bus.palette_color;
            req_bus.source_word   <= item_on_bus.source_word;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      blit_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (result_queue.size() == 0) begin
            $display("%0t: unexpected beat kind=%0d off=%h pix=%h err=%0d", $realtime,
                     rsp_bus.result_kind, rsp_bus.source_offset, rsp_bus.dest_pixel,
                     rsp_bus.format_error);
            error_count++;
         end else begin
            want = result_queue.pop_front();
            if (rsp_bus.result_kind !== want.result_kind) begin
               $display("%0t: result_kind exp %0d got %0d", $realtime,
                        want.result_kind, rsp_bus.result_kind);
               error_count++;
            end
            if (rsp_bus.source_offset !== want.source_offset) begin
               $display("%0t: source_offset exp %h got %h", $realtime,
                        want.source_offset, rsp_bus.source_offset);
               error_count++;
            end
            if (rsp_bus.dest_pixel !== want.dest_pixel) begin
               $display("%0t: dest_pixel exp %h got %h", $realtime,
                        want.dest_pixel, rsp_bus.dest_pixel);
               error_count++;
            end
            if (rsp_bus.format_error !== want.format_error) begin
               $display("%0t: format_error exp %0d got %0d", $realtime,
                        want.format_error, rsp_bus.format_error);
               error_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic csr_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_SRC_WIDTH:  sh_src_w = val[12:0];
         CSR_SRC_HEIGHT: sh_src_h = val[12:0];
         CSR_SRC_STRIDE: sh_stride = val[14:0];
         CSR_DST_WIDTH:  sh_dst_w = val[12:0];
         CSR_DST_HEIGHT: sh_dst_h = val[12:0];
         CSR_SRC_FORMAT: sh_src_fmt = src_fmt_type'(val[1:0]);
         default:        sh_dst_fmt = dst_fmt_type'(val[1:0]);
      endcase
   endtask

   task automatic wait_drained();
      while (item_queue.size() > 0 || req_bus.valid || result_queue.size() > 0)
         @(posedge clock);
      // palette writes leave no trace on the output, so cover the pipe depth
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [12:0] rand_dim();
      if ($urandom_range(9) == 0) return 13'($urandom_range(8191));
      if ($urandom_range(4) == 0) return 13'($urandom_range(4096, 1));
      return 13'($urandom_range(64, 1));
   endfunction

   function automatic blit_item_t rand_item();
      blit_item_t it;
      int sel;
      it.operation     = op_type'($urandom_range(2));
      if ($urandom_range(29) == 0) it.operation = OP_RESERVED;
      it.palette_index = 8'($urandom_range(255));
      it.palette_color = 24'($urandom);
      it.source_word   = $urandom;
      sel = $urandom_range(3);
      if (sel == 0) begin
         it.dest_x = 12'($urandom);
         it.dest_y = 12'($urandom);
      end else begin
         it.dest_x = 12'($urandom_range(clamp_dim(sh_dst_w) - 1));
         it.dest_y = 12'($urandom_range(clamp_dim(sh_dst_h) - 1));
      end
      return it;
   endfunction

   function automatic blit_item_t mk_item(op_type op, logic [11:0] x, logic [11:0] y,
                                          logic [7:0] pi, logic [23:0] pc, logic [31:0] w);
      blit_item_t it;
      it.operation = op; it.dest_x = x; it.dest_y = y;
      it.palette_index = pi; it.palette_color = pc; it.source_word = w;
      return it;
   endfunction

   initial begin
      int phase;
      logic [12:0] dims [4];
      logic [14:0] stride;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_PAL_WRITE;
      req_bus.dest_x = '0;
      req_bus.dest_y = '0;
      req_bus.palette_index = '0;
      req_bus.palette_color = '0;
      req_bus.source_word = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_SRC_WIDTH;
      csr_wr_data = '0;
      send_idle = 37;
      recv_idle = 62;
      error_count = 0;
      sh_src_w = 1; sh_src_h = 1; sh_stride = 4; sh_dst_w = 1; sh_dst_h = 1;
      sh_src_fmt = SRC_BGRA32;
      sh_dst_fmt = DST_ARGB32;
      foreach (sh_palette[i]) sh_palette[i] = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'h0000_0000));
      item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'hFFFF_FFFF));
      item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'h7F12_3456));
      item_queue.push_back(mk_item(OP_ADDR_REQ, 0, 0, 0, 0, 0));
      item_queue.push_back(mk_item(OP_ADDR_REQ, 12'hFFF, 12'hFFF, 0, 0, 0));
      item_queue.push_back(mk_item(OP_RESERVED, 12'hFFF, 12'hFFF, 8'hFF, 24'hFFFFFF, '1));
      item_queue.push_back(mk_item(OP_PAL_WRITE, 0, 0, 8'hFF, 24'hFFFFFF, 0));
      item_queue.push_back(mk_item(OP_PAL_WRITE, 0, 0, 8'h00, 24'h123456, 0));
      wait_drained();

      for (phase = 1; phase <= 29; phase++) begin
         if (phase == 10) begin
            send_idle = 62; recv_idle = 37;
         end else if (phase == 20) begin
            send_idle = 0; recv_idle = 0;
         end
         case (phase)
            1: begin dims = '{13'd4096, 13'd4096, 13'd1, 13'd1}; stride = 15'd16384; end
            2: begin dims = '{13'd0, 13'd0, 13'd0, 13'd0}; stride = 15'd1; end
            3: begin
               dims = '{13'd8191, 13'd8191, 13'd8191, 13'd8191};
               stride = 15'd32767;
            end
            4: begin dims = '{13'd1, 13'd1, 13'd4096, 13'd4096}; stride = 15'd16384; end
            5: begin
               dims = '{13'd4096, 13'd4096, 13'd4096, 13'd4096};
               stride = 15'd16384;
            end
            default: begin
               foreach (dims[i]) dims[i] = rand_dim();
               stride = ($urandom_range(3) == 0) ? 15'($urandom_range(32767))
                                                 : 15'($urandom_range(256, 1));
            end
         endcase
         csr_write(CSR_SRC_WIDTH, CSR_DATA_W'(dims[0]));
         csr_write(CSR_SRC_HEIGHT, CSR_DATA_W'(dims[1]));
         csr_write(CSR_SRC_STRIDE, stride);
         csr_write(CSR_DST_WIDTH, CSR_DATA_W'(dims[2]));
         csr_write(CSR_DST_HEIGHT, CSR_DATA_W'(dims[3]));
         csr_write(CSR_SRC_FORMAT, CSR_DATA_W'(phase % 4));
         csr_write(CSR_DST_FORMAT, CSR_DATA_W'((phase / 4) % 4));
         @(posedge clock);
         csr_wr_en <= 1'b0;
         if (phase == 1) begin
            // far corner coordinates, saturated onto a 1x1 destination from the largest source
            item_queue.push_back(mk_item(OP_ADDR_REQ, 0, 12'hFFF, 0, 0, 0));
            item_queue.push_back(mk_item(OP_ADDR_REQ, 12'hFFF, 0, 0, 0, 0));
            item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'h8000_F81F));
         end
         if (phase == 4) begin
            item_queue.push_back(mk_item(OP_PAL_WRITE, 0, 0, 8'h80, 24'hA5C3E7, 0));
            item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'hFFFF_FF80));
            item_queue.push_back(mk_item(OP_CONVERT, 0, 0, 0, 0, 32'h0000_00FF));
            item_queue.push_back(mk_item(OP_ADDR_REQ, 12'hFFF, 12'hFFF, 0, 0, 0));
         end
         repeat (50) item_queue.push_back(rand_item());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sbpc_pkg.sv
hw/rtl/sbpc_if.sv
hw/rtl/sbpc_ram.sv
hw/rtl/sbpc_div_pipe.sv
hw/rtl/scaled_blit_pixel_converter_unit.sv
verif/tb.sv
